>>> src/sfbcd_pkg.sv
`timescale 1ns / 1ps

package sfbcd_pkg;

  localparam int FREQ_W        = 35;
  localparam logic [FREQ_W-1:0] FREQ_LIMIT = 35'd20000000000;

  localparam int BCD_DIGITS    = 16;
  localparam int BCD_W         = 4 * BCD_DIGITS;

  localparam int SENT_BYTES    = 5;
  localparam int SENT_W        = 8 * SENT_BYTES;

  localparam int BITS_PER_STEP = 5;
  localparam int N_STEPS       = (FREQ_W + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(N_STEPS);

  localparam int ADDR_W        = 3;
  localparam logic [ADDR_W-1:0] ADDR_DATA    = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_TRAILER = 3'd1;

  localparam logic [7:0] DUMMY_BYTE   = 8'h06;
  localparam logic [7:0] TRAILER_BYTE = 8'hFF;

  localparam int WR_W = 3;
  localparam logic [WR_W-1:0] WR_DUMMY      = 3'd0;
  localparam logic [WR_W-1:0] WR_FIRST_BYTE = 3'd1;
  localparam logic [WR_W-1:0] WR_LAST_BYTE  = 3'd5;
  localparam logic [WR_W-1:0] WR_TRAILER    = 3'd6;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic              range_err;
    logic [SENT_W-1:0] inv_bcd;
  } entry_t;

endpackage

>>> src/sfbcd_front.sv
`timescale 1ns / 1ps

module sfbcd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [sfbcd_pkg::FREQ_W-1:0] freq_tenth_hz_i,
  output logic                       push_valid_o,
  input  logic                       push_stall_i,
  output sfbcd_pkg::entry_t          push_entry_o
);
  import sfbcd_pkg::*;

  // shift-add-3 over a few input bits, most significant first
  function automatic logic [BCD_W-1:0] dabble_bits(logic [BCD_W-1:0] bcd,
                                                   logic [BITS_PER_STEP-1:0] bits);
    logic [BCD_W-1:0] acc;
    acc = bcd;
    for (int s = BITS_PER_STEP - 1; s >= 0; s--) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (acc[4*d +: 4] >= 4'd5) begin
          acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
        end
      end
      acc = {acc[BCD_W-2:0], bits[s]};
    end
    return acc;
  endfunction

  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(N_STEPS - 1);
  localparam int BIN_W = N_STEPS * BITS_PER_STEP;

  logic                  busy_q, busy_d;
  logic                  err_q, err_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic [BIN_W-1:0]      bin_q, bin_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic [BCD_W-1:0]      bcd_nx;
  logic                  finishing;
  logic                  accept;

  assign bcd_nx     = dabble_bits(bcd_q, bin_q[BIN_W-1 -: BITS_PER_STEP]);
  assign finishing  = busy_q && (cnt_q == LAST_STEP);
  assign in_stall_o = busy_q && !(finishing && !push_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign push_valid_o           = finishing;
  assign push_entry_o.range_err = err_q;
  assign push_entry_o.inv_bcd   = ~bcd_nx[SENT_W-1:0];

  always_comb begin
    busy_d = busy_q;
    err_d  = err_q;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (accept) begin
      busy_d = 1'b1;
      err_d  = freq_tenth_hz_i > FREQ_LIMIT;
      cnt_d  = '0;
      bin_d  = BIN_W'(freq_tenth_hz_i);
      bcd_d  = '0;
    end else if (finishing) begin
      if (!push_stall_i) begin
        busy_d = 1'b0;
      end
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      bin_d = bin_q << BITS_PER_STEP;
      bcd_d = bcd_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= err_d;
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

endmodule

>>> src/sfbcd_queue.sv
`timescale 1ns / 1ps

module sfbcd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_stall_o,
  input  sfbcd_pkg::entry_t push_entry_i,
  output logic              pop_valid_o,
  input  logic              pop_stall_i,
  output sfbcd_pkg::entry_t pop_entry_o
);
  import sfbcd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  entry_t           slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             push, pop;

  assign push_stall_o = (fill_q == FULL_CNT);
  assign pop_valid_o  = (fill_q != '0);
  assign pop_entry_o  = slot_q[rd_ptr_q];
  assign push = push_valid_i && !push_stall_o;
  assign pop  = pop_valid_o && !pop_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_CNT)
    else $error("queue fill count beyond depth");
  a_fill_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> fill_q == $past(fill_q) + 1'b1)
    else $error("queue fill count missed a push");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0 || fill_q == FULL_CNT) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers out of step with fill count");
`endif

endmodule

>>> src/sfbcd_back.sv
`timescale 1ns / 1ps

module sfbcd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  output logic                         pop_stall_o,
  input  sfbcd_pkg::entry_t            pop_entry_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sfbcd_pkg::ADDR_W-1:0] aux_address_o,
  output logic [7:0]                   aux_data_o,
  output logic                         last_write_o,
  output logic                         range_error_o
);
  import sfbcd_pkg::*;

  logic [WR_W-1:0]   wr_idx_q, wr_idx_d;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [7:0]        data_q, data_d;
  logic              last_q, last_d;
  logic              err_q, err_d;
  logic              advance, issue, is_last;
  logic [WR_W-1:0]   byte_sel;
  logic [SENT_W-1:0] shifted;

  assign advance  = !out_valid_q || !out_stall_i;
  assign issue    = advance && pop_valid_i;
  assign byte_sel = wr_idx_q - WR_FIRST_BYTE;
  assign shifted  = pop_entry_i.inv_bcd >> {byte_sel, 3'b000};

  always_comb begin
    addr_d  = ADDR_DATA;
    data_d  = DUMMY_BYTE;
    is_last = 1'b0;
    if (pop_entry_i.range_err) begin
      data_d  = 8'h00;
      is_last = 1'b1;
    end else begin
      unique case (wr_idx_q) inside
        WR_DUMMY: begin
          data_d = DUMMY_BYTE;
        end
        [WR_FIRST_BYTE:WR_LAST_BYTE]: begin
          data_d = shifted[7:0];
        end
        WR_TRAILER: begin
          addr_d  = ADDR_TRAILER;
          data_d  = TRAILER_BYTE;
          is_last = 1'b1;
        end
        default: begin
          data_d = DUMMY_BYTE;
        end
      endcase
    end
  end

  assign last_d      = is_last;
  assign err_d       = pop_entry_i.range_err;
  assign pop_stall_o = !(issue && is_last);

  always_comb begin
    wr_idx_d    = wr_idx_q;
    out_valid_d = out_valid_q;
    if (issue) begin
      out_valid_d = 1'b1;
      wr_idx_d    = is_last ? WR_DUMMY : wr_idx_q + 1'b1;
    end else if (advance) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q    <= WR_DUMMY;
      out_valid_q <= 1'b0;
    end else begin
      wr_idx_q    <= wr_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      addr_q <= addr_d;
      data_q <= data_d;
      last_q <= last_d;
      err_q  <= err_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign aux_address_o = addr_q;
  assign aux_data_o    = data_q;
  assign last_write_o  = last_q;
  assign range_error_o = err_q;

`ifndef NO_ASSERTIONS
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> last_write_o)
    else $error("range error result not marked last");
  a_trailer_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_write_o && !range_error_o) |->
      (aux_address_o == ADDR_TRAILER && aux_data_o == TRAILER_BYTE))
    else $error("final write is not the trailer");
  a_idx_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && is_last) |=> wr_idx_q == WR_DUMMY)
    else $error("write index not rewound after a run");
`endif

endmodule

>>> src/synth_freq_bcd_byte_writer_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in        request    in_valid_i/in_stall_o freq_tenth_hz_i
// out       result     out_valid_o/out_stall_i aux_address_o, aux_data_o,
//                                            last_write_o, range_error_o
//
// The front converter takes five input bits a cycle; the next request is
// taken as the finished entry enters the queue. The back issues one bus
// write per cycle while an entry waits and the output is not stalled: 7 per
// request, or one flagged result for a frequency above 2000 MHz. Reset clears
// the busy flag, step counter, queue pointers, fill count, write index and
// output valid only; a stalled output holds the back, a full queue the front.
module synth_freq_bcd_byte_writer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sfbcd_pkg::FREQ_W-1:0] freq_tenth_hz_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sfbcd_pkg::ADDR_W-1:0] aux_address_o,
  output logic [7:0]                   aux_data_o,
  output logic                         last_write_o,
  output logic                         range_error_o
);
  import sfbcd_pkg::*;

  // converted requests travel front to back as queue entries
  logic   push_valid, push_stall;
  entry_t push_entry;
  logic   pop_valid, pop_stall;
  entry_t pop_entry;

  // front: classify the range, then run the binary to BCD conversion
  sfbcd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .freq_tenth_hz_i (freq_tenth_hz_i),
    .push_valid_o    (push_valid),
    .push_stall_i    (push_stall),
    .push_entry_o    (push_entry)
  );

  // two-entry queue decouples conversion from the bus writes
  sfbcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_stall_o (push_stall),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_stall_i  (pop_stall),
    .pop_entry_o  (pop_entry)
  );

  // back: sequence dummy byte, five inverted BCD bytes and the trailer, or a single flagged result
  sfbcd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_stall_o   (pop_stall),
    .pop_entry_i   (pop_entry),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .aux_address_o (aux_address_o),
    .aux_data_o    (aux_data_o),
    .last_write_o  (last_write_o),
    .range_error_o (range_error_o)
  );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sfbcd_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [7:0]        data;
    logic              last;
    logic              range_err;
  } bus_write_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  localparam logic [63:0] IN_RANGE_SPAN = 64'(FREQ_LIMIT) + 64'd1;
  localparam int          SETTLE_CYCLES = 30;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [FREQ_W-1:0] freq_tenth_hz_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ADDR_W-1:0] aux_address_o;
  logic [7:0]        aux_data_o;
  logic              last_write_o;
  logic              range_error_o;

  bus_write_t  pending_writes[$];
  bus_write_t  seen_write;
  bus_write_t  wanted_write;
  int          failures = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  synth_freq_bcd_byte_writer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .freq_tenth_hz_i(freq_tenth_hz_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .aux_address_o  (aux_address_o),
    .aux_data_o     (aux_data_o),
    .last_write_o   (last_write_o),
    .range_error_o  (range_error_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Queue the bus writes that one accepted frequency must produce.
  function automatic void predict_writes(input logic [FREQ_W-1:0] freq);
    logic [63:0] remainder;
    logic [63:0] bcd_word;
    logic [63:0] inv_word;
    remainder = 64'(freq);
    bcd_word  = '0;
    if (freq > FREQ_LIMIT) begin
      pending_writes.push_back('{address: '0, data: '0, last: 1'b1, range_err: 1'b1});
      return;
    end
    for (int d = 0; d < BCD_DIGITS; d++) begin
      bcd_word[4*d +: 4] = 4'(remainder % 64'd10);
      remainder          = remainder / 64'd10;
    end
    inv_word = ~bcd_word;
    pending_writes.push_back('{address: ADDR_DATA, data: DUMMY_BYTE, last: 1'b0,
                               range_err: 1'b0});
    for (int b = 0; b < SENT_BYTES; b++)
      pending_writes.push_back('{address: ADDR_DATA, data: inv_word[8*b +: 8], last: 1'b0,
                                 range_err: 1'b0});
    pending_writes.push_back('{address: ADDR_TRAILER, data: TRAILER_BYTE, last: 1'b1,
                               range_err: 1'b0});
  endfunction

  // Check results against the oldest expectation, then predict from the new request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen_write = {aux_address_o, aux_data_o, last_write_o, range_error_o};
        if (pending_writes.size() == 0) begin
          failures++;
          $display("%0t: unexpected write addr=%0h data=%02h last=%0b err=%0b",
                   $time, seen_write.address, seen_write.data, seen_write.last,
                   seen_write.range_err);
        end else begin
          wanted_write = pending_writes.pop_front();
          if (seen_write !== wanted_write) begin
            failures++;
            $display("%0t: expected addr=%0h data=%02h last=%0b err=%0b, got addr=%0h data=%02h last=%0b err=%0b",
                     $time, wanted_write.address, wanted_write.data, wanted_write.last,
                     wanted_write.range_err, seen_write.address, seen_write.data,
                     seen_write.last, seen_write.range_err);
          end
        end
      end
      if (in_valid_i && !in_stall_o)
        predict_writes(freq_tenth_hz_i);
    end
  end

  // Stall the result side in phases: none, light, heavy, or a fixed rhythm.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 7);
      default:     out_stall_i <= ((stall_left % 11) < 4);
    endcase
  end

  // Offer one request and hold it until taken; gap between bursts.
  task automatic send_request(input logic [FREQ_W-1:0] freq);
    int gap;
    freq_tenth_hz_i <= freq;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic wait_writes_done();
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic test_digit_extremes();
    send_request(35'd0);
    send_request(35'd1);
    send_request(35'd9);
    send_request(35'd10);
    send_request(35'd9999999999);
    send_request(35'd12345678901);
    send_request(35'd19999999999);
    // exactly 2000 MHz is still in range; its eleventh digit is dropped
    send_request(FREQ_LIMIT);
    wait_writes_done();
  endtask

  task automatic test_range_error();
    send_request(FREQ_LIMIT + 35'd1);
    send_request(35'h7_FFFF_FFFF);
    send_request(35'h5_5555_5555);
    send_request(FREQ_LIMIT + 35'd1);
    send_request(35'd5);
    send_request(35'h4_0000_0000);
    wait_writes_done();
  endtask

  task automatic test_bit_patterns();
    send_request(35'h2_AAAA_AAAA);
    send_request(35'h0_5555_5555);
    send_request(35'h3_FFFF_FFFF);
    send_request(35'h1_0000_0001);
    wait_writes_done();
  endtask

  task automatic test_random_freqs(input int count);
    logic [63:0] raw;
    int          kind;
    for (int i = 0; i < count; i++) begin
      raw  = {$urandom, $urandom};
      kind = $urandom_range(0, 9);
      if (kind <= 5)
        raw = raw % IN_RANGE_SPAN;
      else if (kind == 6)
        raw = 64'($urandom_range(0, 9999));
      else if (kind == 7)
        raw = 64'(FREQ_LIMIT) - 64'd50 + 64'($urandom_range(0, 100));
      send_request(raw[FREQ_W-1:0]);
    end
    wait_writes_done();
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_digit_extremes();
    test_range_error();
    test_bit_patterns();
    test_random_freqs(252);
    if (failures == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
